>>> rtl/iudp_pkg.sv
// Shared types, codes and constants for the IPv4/UDP checksum fixup block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package iudp_pkg;

    // Word kinds carried on the input tuser
    localparam logic [1:0] ACT_IP      = 2'd0;
    localparam logic [1:0] ACT_UDP     = 2'd1;
    localparam logic [1:0] ACT_PAYLOAD = 2'd2;

    // Header layout (no IP options)
    localparam logic [3:0] IP_HEADER_WORDS  = 4'd10;
    localparam logic [2:0] UDP_HEADER_WORDS = 3'd4;
    localparam logic [3:0] IP_W_TOTLEN      = 4'd1;
    localparam logic [3:0] IP_W_PROTO       = 4'd4;
    localparam logic [3:0] IP_W_CSUM        = 4'd5;
    localparam logic [3:0] IP_W_SRC_ADDR    = 4'd6;
    localparam logic [2:0] UDP_W_LEN        = 3'd2;

    // Payload byte counter saturates here
    localparam logic [16:0] PAYLOAD_MAX = 17'h1ffff;

    // Header byte counts added to the payload length
    localparam logic [17:0] UDP_HDR_BYTES    = 18'd8;
    localparam logic [17:0] IP_UDP_HDR_BYTES = 18'd28;
    localparam logic [17:0] MAX_IP_LEN       = 18'h0ffff;

    // One input item as registered at the block boundary
    typedef struct packed {
        logic        last;
        logic [1:0]  byte_count;
        logic [15:0] word;
        logic [1:0]  action;
    } item_t;

    // Per-packet totals after the final item, handed to the finishing stage
    typedef struct packed {
        logic [15:0] ip_sum;
        logic [15:0] udp_sum;
        logic [16:0] payload_bytes;
        logic        error;
    } totals_t;

    // One result item
    typedef struct packed {
        logic [15:0] ip_total_length;
        logic [15:0] udp_length;
        logic [15:0] ip_checksum;
        logic [15:0] udp_checksum;
        logic        format_error;
    } result_t;

    // 16-bit one's-complement add with end-around carry
    function automatic logic [15:0] oc_add16(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

endpackage

>>> rtl/iudp_accum.sv
// Per-packet state: header word indexes, one's-complement sums and payload byte count.
// Depends on iudp_pkg.
`timescale 1ns / 1ps

module iudp_accum import iudp_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    advance,   // item in the input register is consumed this cycle
    input  item_t   item,
    output totals_t totals     // state including this item
);

    logic [3:0]  ip_idx_reg,    ip_idx_next;
    logic [2:0]  udp_idx_reg,   udp_idx_next;
    logic [15:0] ip_sum_reg,    ip_sum_next;
    logic [15:0] udp_sum_reg,   udp_sum_next;
    logic [16:0] pay_bytes_reg, pay_bytes_next;
    logic        err_reg,       err_next;
    logic [17:0] pay_sum;

    // Fold one item into the running state
    always_comb begin
        ip_idx_next    = ip_idx_reg;
        udp_idx_next   = udp_idx_reg;
        ip_sum_next    = ip_sum_reg;
        udp_sum_next   = udp_sum_reg;
        pay_bytes_next = pay_bytes_reg;
        err_next       = err_reg;
        pay_sum        = {1'b0, pay_bytes_reg};

        case (item.action)
            ACT_IP: begin
                if (ip_idx_reg >= IP_HEADER_WORDS) begin
                    err_next = 1'b1;
                end else begin
                    // total length and checksum words are replaced, so skipped
                    if (ip_idx_reg != IP_W_TOTLEN && ip_idx_reg != IP_W_CSUM) begin
                        ip_sum_next = oc_add16(ip_sum_reg, item.word);
                    end
                    // pseudo-header: addresses and protocol byte
                    if (ip_idx_reg >= IP_W_SRC_ADDR) begin
                        udp_sum_next = oc_add16(udp_sum_reg, item.word);
                    end else if (ip_idx_reg == IP_W_PROTO) begin
                        udp_sum_next = oc_add16(udp_sum_reg, {8'h00, item.word[7:0]});
                    end
                    ip_idx_next = ip_idx_reg + 4'd1;
                end
            end
            ACT_UDP: begin
                if (udp_idx_reg >= UDP_HEADER_WORDS) begin
                    err_next = 1'b1;
                end else begin
                    // ports only; length and checksum words are replaced
                    if (udp_idx_reg < UDP_W_LEN) begin
                        udp_sum_next = oc_add16(udp_sum_reg, item.word);
                    end
                    udp_idx_next = udp_idx_reg + 3'd1;
                end
            end
            ACT_PAYLOAD: begin
                if (item.byte_count == 2'd1) begin
                    udp_sum_next = oc_add16(udp_sum_reg, {item.word[15:8], 8'h00});
                    pay_sum      = {1'b0, pay_bytes_reg} + 18'd1;
                end else if (item.byte_count inside {2'd2, 2'd3}) begin
                    udp_sum_next = oc_add16(udp_sum_reg, item.word);
                    pay_sum      = {1'b0, pay_bytes_reg} + 18'd2;
                end
                pay_bytes_next = pay_sum[17] ? PAYLOAD_MAX : pay_sum[16:0];
            end
            default: begin
                // unused kind adds nothing
            end
        endcase
    end

    // Totals seen by the finishing stage
    always_comb begin
        totals.ip_sum        = ip_sum_next;
        totals.udp_sum       = udp_sum_next;
        totals.payload_bytes = pay_bytes_next;
        totals.error         = err_next
                             | (ip_idx_next != IP_HEADER_WORDS)
                             | (udp_idx_next != UDP_HEADER_WORDS);
    end

    // State update; a final item returns everything to the reset state
    always_ff @(posedge aclk) begin
        if (!aresetn || (advance && item.last)) begin
            ip_idx_reg    <= '0;
            udp_idx_reg   <= '0;
            ip_sum_reg    <= '0;
            udp_sum_reg   <= '0;
            pay_bytes_reg <= '0;
            err_reg       <= 1'b0;
        end else if (advance) begin
            ip_idx_reg    <= ip_idx_next;
            udp_idx_reg   <= udp_idx_next;
            ip_sum_reg    <= ip_sum_next;
            udp_sum_reg   <= udp_sum_next;
            pay_bytes_reg <= pay_bytes_next;
            err_reg       <= err_next;
        end
    end

endmodule

>>> rtl/iudp_final.sv
// Finishing logic: lengths, length check and complemented folded checksums.
// Depends on iudp_pkg.
`timescale 1ns / 1ps

module iudp_final import iudp_pkg::*; (
    input  totals_t totals,
    output result_t result
);

    logic [17:0] udp_len_w;
    logic [17:0] ip_len_w;
    logic [15:0] udp_len;
    logic [15:0] ip_len;
    logic [17:0] ua_sum;
    logic [16:0] ua_fold;
    logic [15:0] ua_final;
    logic [16:0] ia_sum;
    logic [15:0] ia_final;

    // Lengths from the payload count
    always_comb begin
        udp_len_w = {1'b0, totals.payload_bytes} + UDP_HDR_BYTES;
        ip_len_w  = {1'b0, totals.payload_bytes} + IP_UDP_HDR_BYTES;
        udp_len   = udp_len_w[15:0];
        ip_len    = ip_len_w[15:0];
    end

    // UDP: pseudo-header length plus header length field, then fold
    always_comb begin
        ua_sum   = {2'b00, totals.udp_sum} + {2'b00, udp_len} + {2'b00, udp_len};
        ua_fold  = {1'b0, ua_sum[15:0]} + {15'd0, ua_sum[17:16]};
        ua_final = ua_fold[15:0] + {15'd0, ua_fold[16]};
    end

    // IPv4: new total length, then fold
    always_comb begin
        ia_sum   = {1'b0, totals.ip_sum} + {1'b0, ip_len};
        ia_final = ia_sum[15:0] + {15'd0, ia_sum[16]};
    end

    always_comb begin
        result.udp_checksum    = ~ua_final;
        result.ip_checksum     = ~ia_final;
        result.udp_length      = udp_len;
        result.ip_total_length = ip_len;
        result.format_error    = totals.error | (ip_len_w > MAX_IP_LEN);
    end

endmodule

>>> rtl/ipv4_udp_checksum_fixup.sv
// Top level of the IPv4/UDP length and checksum fixup block.
// Depends on iudp_pkg, iudp_accum and iudp_final.
`timescale 1ns / 1ps

// Takes one packet as big-endian 16-bit words (ten IPv4 header words, four UDP
// header words, payload) and, on the item marked tlast, gives one result item with
// the UDP checksum, IPv4 header checksum, UDP length and IP total length, plus a
// format error flag in m_tuser. Length and checksum words of the incoming headers
// are ignored. One item is accepted per cycle while input is not stalled; a result
// is presented once its last item has passed from the input register through the
// totals register, then the output register. The per-item critical path is the
// 16-bit end-around-carry add into the running sums. Back-pressure on m_tready
// stalls input only once the pipeline holds a pending result at every stage.

module ipv4_udp_checksum_fixup import iudp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [15:0] word, [17:16] byte_count, [23:18] zero
    input  logic [1:0]  s_tuser,   // [1:0] action
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [15:0] udp_checksum, [31:16] ip_checksum,
                                   // [47:32] udp_length, [63:48] ip_total_length
    output logic [0:0]  m_tuser    // [0] format_error
);

    logic    in_valid_reg;
    item_t   in_item_reg;
    logic    snap_valid_reg;
    totals_t snap_reg;
    logic    out_valid_reg;
    result_t out_reg;

    logic    out_ready;
    logic    snap_ready;
    logic    in_adv;
    logic    in_load;
    totals_t totals;
    result_t result;

    // Stage handshakes
    assign out_ready  = !out_valid_reg || m_tready;
    assign snap_ready = !snap_valid_reg || out_ready;
    assign in_adv     = in_valid_reg && (!in_item_reg.last || snap_ready);
    assign s_tready   = !in_valid_reg || in_adv;
    assign in_load    = s_tvalid && s_tready;

    iudp_accum u_accum (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (in_adv),
        .item    (in_item_reg),
        .totals  (totals)
    );

    iudp_final u_final (
        .totals (snap_reg),
        .result (result)
    );

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            snap_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (in_load) begin
                in_valid_reg <= 1'b1;
            end else if (in_adv) begin
                in_valid_reg <= 1'b0;
            end
            if (in_adv && in_item_reg.last) begin
                snap_valid_reg <= 1'b1;
            end else if (out_ready) begin
                snap_valid_reg <= 1'b0;
            end
            if (snap_valid_reg && out_ready) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Data registers
    always_ff @(posedge aclk) begin
        if (in_load) begin
            in_item_reg.action     <= s_tuser;
            in_item_reg.word       <= s_tdata[15:0];
            in_item_reg.byte_count <= s_tdata[17:16];
            in_item_reg.last       <= s_tlast;
        end
        if (in_adv && in_item_reg.last) begin
            snap_reg <= totals;
        end
        if (snap_valid_reg && out_ready) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.ip_total_length, out_reg.udp_length,
                       out_reg.ip_checksum, out_reg.udp_checksum};
    assign m_tuser  = out_reg.format_error;

    // A consumed final item always reaches the totals register
    a_last_to_snap: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_adv && in_item_reg.last) |=> snap_valid_reg)
        else $error("final item did not reach totals register");

    // Totals handed on always produce an output item
    a_snap_to_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (snap_valid_reg && out_ready) |=> out_valid_reg)
        else $error("totals lost before output register");

    // Input stalls only when every stage holds a pending result
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid_reg && in_item_reg.last && snap_valid_reg
                       && out_valid_reg && !m_tready))
        else $error("input stalled without full pipeline");

    // The two lengths differ by the IPv4 header size
    a_len_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_reg.ip_total_length == out_reg.udp_length + 16'd20))
        else $error("IP and UDP lengths inconsistent");

endmodule
